/* hw/rtl/dwpi_pkg.sv */
// Types and constants shared by the dual-wheel PI velocity loop.
package dwpi_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_FEEDFORWARD_GAIN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROPORTIONAL_GAIN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTEGRAL_GAIN     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTEGRAL_LIMIT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RISE_STEP         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_LIMIT      = 3'd5;

    localparam logic [15:0] FEEDFORWARD_GAIN_RST  = 16'd512;
    localparam logic [15:0] PROPORTIONAL_GAIN_RST = 16'd128;
    localparam logic [15:0] INTEGRAL_GAIN_RST     = 16'd164;
    localparam logic [11:0] INTEGRAL_LIMIT_RST    = 12'd500;
    localparam logic [11:0] RISE_STEP_RST         = 12'd20;
    localparam logic [11:0] OUTPUT_LIMIT_RST      = 12'd1200;

    typedef struct packed {
        logic               clear_state;
        logic signed [15:0] left_target;
        logic signed [15:0] right_target;
        logic signed [15:0] measured_left;
        logic signed [15:0] measured_right;
    } dwpi_in_t;

    typedef struct packed {
        logic [11:0] left_pwm;
        logic [11:0] right_pwm;
    } dwpi_out_t;

    typedef struct packed {
        logic [27:0]        drive;
        logic signed [28:0] accum;
    } dwpi_wheel_t;

endpackage

/* hw/rtl/dual_wheel_pi_velocity_loop_core.sv */
// Top level of the dual-wheel PI velocity loop with feedforward and slew limit.
// An accepted item waits in the input register while a result is held and not taken.
// Throughput: one item per cycle otherwise; the wheel update is one pass of multiply, add
// and clamp logic between the input and result registers, with the state fed back.
// Reset: synchronous active-low; gains and limits take their default values and both
// wheels' drive and integral state clear to zero.
module dual_wheel_pi_velocity_loop_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  dwpi_pkg::dwpi_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output dwpi_pkg::dwpi_out_t                 m_data,
    input  logic                                cfg_we,
    input  logic [dwpi_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dwpi_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dwpi_pkg::*;

    logic [15:0] ff_gain_reg;
    logic [15:0] kp_gain_reg;
    logic [15:0] ki_gain_reg;
    logic [11:0] int_limit_reg;
    logic [11:0] rise_step_reg;
    logic [11:0] out_limit_reg;

    logic        in_valid_reg;
    dwpi_in_t    in_data_reg;
    logic        out_valid_reg;
    dwpi_out_t   out_data_reg;
    dwpi_wheel_t left_reg;
    dwpi_wheel_t right_reg;

    dwpi_wheel_t left_next;
    dwpi_wheel_t right_next;
    logic        advance;

    function automatic dwpi_wheel_t wheel_step(
        input logic signed [15:0] tgt,
        input logic signed [15:0] meas,
        input dwpi_wheel_t        cur,
        input logic [15:0]        ff,
        input logic [15:0]        kp,
        input logic [15:0]        ki,
        input logic [11:0]        il,
        input logic [11:0]        rs,
        input logic [11:0]        ol
    );
        logic signed [16:0] err;
        logic signed [33:0] ki_prod;
        logic signed [32:0] ff_prod;
        logic signed [33:0] kp_prod;
        logic signed [30:0] cand;
        logic signed [30:0] lim;
        logic signed [39:0] desired;
        logic [28:0]        cap;
        logic [28:0]        top;
        dwpi_wheel_t        res;
        err     = {tgt[15], tgt} - {meas[15], meas};
        ki_prod = $signed({1'b0, ki}) * err;
        cand    = 31'(cur.accum) + 31'(ki_prod >>> 4);
        lim     = $signed({3'b000, il, 16'h0000});
        if (cand > lim) begin
            cand = lim;
        end
        if (cand < -lim) begin
            cand = -lim;
        end
        ff_prod = $signed({1'b0, ff}) * tgt;
        kp_prod = $signed({1'b0, kp}) * err;
        desired = (40'(ff_prod) <<< 4) + (40'(kp_prod) <<< 4) + 40'(cand);
        cap = {1'b0, cur.drive} + {1'b0, rs, 16'h0000};
        top = {1'b0, ol, 16'h0000};
        if (cap > top) begin
            cap = top;
        end
        res = cur;
        if (tgt[15] || (tgt == 16'sd0)) begin
            res = '0;
        end else if (desired > $signed({11'b0, cap})) begin
            if (err < 17'sd0) begin
                res.accum = cand[28:0];
            end
            res.drive = cap[27:0];
        end else if (desired < 40'sd0) begin
            if (err > 17'sd0) begin
                res.accum = cand[28:0];
            end
            res.drive = '0;
        end else begin
            res.accum = cand[28:0];
            res.drive = desired[27:0];
        end
        return res;
    endfunction

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        if (in_data_reg.clear_state) begin
            left_next  = '0;
            right_next = '0;
        end else begin
            left_next  = wheel_step(in_data_reg.left_target, in_data_reg.measured_left,
                                    left_reg, ff_gain_reg, kp_gain_reg, ki_gain_reg,
                                    int_limit_reg, rise_step_reg, out_limit_reg);
            right_next = wheel_step(in_data_reg.right_target, in_data_reg.measured_right,
                                    right_reg, ff_gain_reg, kp_gain_reg, ki_gain_reg,
                                    int_limit_reg, rise_step_reg, out_limit_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ff_gain_reg   <= FEEDFORWARD_GAIN_RST;
            kp_gain_reg   <= PROPORTIONAL_GAIN_RST;
            ki_gain_reg   <= INTEGRAL_GAIN_RST;
            int_limit_reg <= INTEGRAL_LIMIT_RST;
            rise_step_reg <= RISE_STEP_RST;
            out_limit_reg <= OUTPUT_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FEEDFORWARD_GAIN:  ff_gain_reg   <= cfg_data[15:0];
                CFG_PROPORTIONAL_GAIN: kp_gain_reg   <= cfg_data[15:0];
                CFG_INTEGRAL_GAIN:     ki_gain_reg   <= cfg_data[15:0];
                CFG_INTEGRAL_LIMIT:    int_limit_reg <= cfg_data[11:0];
                CFG_RISE_STEP:         rise_step_reg <= cfg_data[11:0];
                CFG_OUTPUT_LIMIT:      out_limit_reg <= cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                left_reg      <= left_next;
                right_reg     <= right_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg.left_pwm  <= left_next.drive[27:16];
            out_data_reg.right_pwm <= right_next.drive[27:16];
        end
    end

    a_ready_when_output_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("Input stalled while the result register is free.");

    a_clear_zeroes_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_data_reg.clear_state) |=>
        (left_reg == '0) && (right_reg == '0) && (m_data == '0))
        else $error("Clear request left wheel state or result nonzero.");

    a_result_matches_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid && (m_data.left_pwm == left_reg.drive[27:16])
        && (m_data.right_pwm == right_reg.drive[27:16]))
        else $error("Result item does not match the updated drive state.");

endmodule

/* verif/dwpi_loop_checker.sv */
`timescale 1ns / 100ps
// Checker that tracks the velocity loop's registers and wheel state and compares its PWM results.
module dwpi_loop_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  dwpi_pkg::dwpi_in_t               s_data,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  dwpi_pkg::dwpi_out_t              m_data,
    input  logic                             cfg_we,
    input  logic [dwpi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dwpi_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               outstanding,
    output int                               results_seen,
    output int                               fail_count
);
    import dwpi_pkg::*;

    logic [15:0] ff_gain;
    logic [15:0] kp_gain;
    logic [15:0] ki_gain;
    logic [11:0] int_limit;
    logic [11:0] rise_limit;
    logic [11:0] out_limit;

    dwpi_wheel_t left_w;
    dwpi_wheel_t right_w;
    dwpi_out_t   pwm_expected_q [$];
    dwpi_out_t   pwm_want;
    dwpi_out_t   pwm_next;
    int          n_fail = 0;
    int          n_seen = 0;

    function automatic dwpi_wheel_t wheel_update(input dwpi_wheel_t w,
                                                 input logic signed [15:0] tgt,
                                                 input logic signed [15:0] meas);
        longint      t;
        longint      m;
        longint      e;
        longint      drv;
        longint      acc;
        longint      cand;
        longint      lim;
        longint      want;
        longint      cap;
        longint      top;
        dwpi_wheel_t nw;
        t   = tgt;
        m   = meas;
        drv = longint'(w.drive);
        acc = longint'(w.accum);
        if (t <= 0) begin
            return '0;
        end
        e    = t - m;
        cand = acc + ((longint'(ki_gain) * e) >>> 4);
        lim  = longint'(int_limit) <<< 16;
        if (cand > lim) cand = lim;
        if (cand < -lim) cand = -lim;
        want = longint'(ff_gain) * t * 16 + longint'(kp_gain) * e * 16 + cand;
        cap  = drv + (longint'(rise_limit) <<< 16);
        top  = longint'(out_limit) <<< 16;
        if (cap > top) cap = top;
        if (want > cap) begin
            if (e < 0) acc = cand;
            drv = cap;
        end else if (want < 0) begin
            if (e > 0) acc = cand;
            drv = 0;
        end else begin
            acc = cand;
            drv = want;
        end
        nw.drive = drv[27:0];
        nw.accum = acc[28:0];
        return nw;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            ff_gain    = FEEDFORWARD_GAIN_RST;
            kp_gain    = PROPORTIONAL_GAIN_RST;
            ki_gain    = INTEGRAL_GAIN_RST;
            int_limit  = INTEGRAL_LIMIT_RST;
            rise_limit = RISE_STEP_RST;
            out_limit  = OUTPUT_LIMIT_RST;
            left_w     = '0;
            right_w    = '0;
            pwm_expected_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FEEDFORWARD_GAIN:  ff_gain    = cfg_data;
                    CFG_PROPORTIONAL_GAIN: kp_gain    = cfg_data;
                    CFG_INTEGRAL_GAIN:     ki_gain    = cfg_data;
                    CFG_INTEGRAL_LIMIT:    int_limit  = cfg_data[11:0];
                    CFG_RISE_STEP:         rise_limit = cfg_data[11:0];
                    CFG_OUTPUT_LIMIT:      out_limit  = cfg_data[11:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                n_seen++;
                if (pwm_expected_q.size() == 0) begin
                    n_fail++;
                    $error("unexpected result: left_pwm %0d right_pwm %0d",
                           m_data.left_pwm, m_data.right_pwm);
                end else begin
                    pwm_want = pwm_expected_q.pop_front();
                    if (m_data.left_pwm !== pwm_want.left_pwm) begin
                        n_fail++;
                        $error("left_pwm: expected %0d, actual %0d",
                               pwm_want.left_pwm, m_data.left_pwm);
                    end
                    if (m_data.right_pwm !== pwm_want.right_pwm) begin
                        n_fail++;
                        $error("right_pwm: expected %0d, actual %0d",
                               pwm_want.right_pwm, m_data.right_pwm);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_data.clear_state) begin
                    left_w  = '0;
                    right_w = '0;
                end else begin
                    left_w  = wheel_update(left_w, s_data.left_target, s_data.measured_left);
                    right_w = wheel_update(right_w, s_data.right_target, s_data.measured_right);
                end
                pwm_next.left_pwm  = left_w.drive[27:16];
                pwm_next.right_pwm = right_w.drive[27:16];
                pwm_expected_q.push_back(pwm_next);
            end
        end
        outstanding  <= pwm_expected_q.size();
        results_seen <= n_seen;
        fail_count   <= n_fail;
    end

endmodule

/* verif/tb_dual_wheel_pi_velocity_loop_core.sv */
`timescale 1ns / 100ps
// Testbench top for the dual-wheel PI velocity loop: stimulus, register settings and verdict.
module tb_dual_wheel_pi_velocity_loop_core;
    import dwpi_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 60;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = CFG_OUTPUT_LIMIT + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = '1;
    localparam logic [CFG_INDEX_W-1:0] REG_ORDER [6] = '{
        CFG_FEEDFORWARD_GAIN, CFG_PROPORTIONAL_GAIN, CFG_INTEGRAL_GAIN,
        CFG_INTEGRAL_LIMIT, CFG_RISE_STEP, CFG_OUTPUT_LIMIT
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    dwpi_in_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    dwpi_out_t              m_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int outstanding;
    int results_seen;
    int fail_count;
    int burst_left    = 0;
    int rx_hold       = 0;
    int idle_cycles   = 0;
    int items_sent    = 0;
    int settings_used = 0;

    logic [CFG_DATA_W-1:0] reg_plan [6];

    dual_wheel_pi_velocity_loop_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dwpi_loop_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .fail_count   (fail_count)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_dual_wheel_pi_velocity_loop_core: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else if ($urandom_range(0, 9) < 6) begin
            m_ready <= 1'b1;
            rx_hold <= $urandom_range(0, 40);
        end else begin
            m_ready <= 1'b0;
            rx_hold <= $urandom_range(0, 12);
        end
    end

    function automatic dwpi_in_t pack_item(input logic clr, input int tl, input int ml,
                                           input int tr, input int mr);
        dwpi_in_t it;
        it.clear_state    = clr;
        it.left_target    = 16'(tl);
        it.right_target   = 16'(tr);
        it.measured_left  = 16'(ml);
        it.measured_right = 16'(mr);
        return it;
    endfunction

    function automatic void pick_wheel(output logic signed [15:0] tgt,
                                       output logic signed [15:0] meas);
        int sel;
        int t;
        int m;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            tgt  = 16'($urandom);
            meas = 16'($urandom);
        end else if (sel == 1) begin
            t    = -int'($urandom_range(0, 32768));
            tgt  = 16'(t);
            meas = 16'($urandom);
        end else begin
            t = $urandom_range(1, (sel < 6) ? 1500 : 32767);
            m = t + int'($urandom_range(0, 800)) - 400;
            if (m > 32767) m = 32767;
            tgt  = 16'(t);
            meas = 16'(m);
        end
    endfunction

    function automatic dwpi_in_t make_item();
        dwpi_in_t it;
        it.clear_state = ($urandom_range(0, 24) == 0);
        pick_wheel(it.left_target, it.measured_left);
        pick_wheel(it.right_target, it.measured_right);
        return it;
    endfunction

    task automatic send_item(input dwpi_in_t item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic load_config();
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data  <= reg_plan[i];
            @(posedge aclk);
        end
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPARE_LO;
        cfg_data  <= 16'($urandom);
        @(posedge aclk);
        cfg_index <= CFG_SPARE_HI;
        cfg_data  <= 16'($urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        settings_used++;
    endtask

    task automatic plan_random();
        reg_plan[0] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
        reg_plan[1] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512));
        reg_plan[2] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        reg_plan[3] = {4'($urandom), 12'($urandom_range(0, 4095))};
        reg_plan[4] = {4'($urandom), ($urandom_range(0, 3) == 0) ?
                       12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 150))};
        reg_plan[5] = {4'($urandom), 12'($urandom)};
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(pack_item(1'b1, 32767, 32767, 32767, 32767));
        send_item(pack_item(1'b1, -32768, -32768, -32768, -32768));
        for (int i = 0; i < 4; i++) begin
            send_item(pack_item(1'b0, 32767, -32768, 32767, 32767));
        end
        send_item(pack_item(1'b0, 0, 100, -32768, 0));
        send_item(pack_item(1'b0, 16, 32767, 1, -32768));
        for (int i = 0; i < 6; i++) begin
            send_item(pack_item(1'b0, 800, 800, 400, 300));
        end
        send_item(pack_item(1'b0, 800, 32767, 400, 32767));
        send_item(pack_item(1'b0, 32767, 0, 32767, 32000));
        send_item(pack_item(1'b1, 32767, 0, 32767, 0));
        wait_idle();

        reg_plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        load_config();
        for (int i = 0; i < 3; i++) begin
            send_item(pack_item(1'b0, 32767, 0, 20000, 19000));
        end
        wait_idle();
        reg_plan[5] = 16'd100;
        load_config();
        send_item(pack_item(1'b0, 32767, 0, 20000, 19000));
        send_item(pack_item(1'b0, 32767, 32767, 20000, 30000));

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            if (phase == 0) begin
                reg_plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0FFF, 16'h0FFF, 16'h0FFF};
            end else if (phase == 1) begin
                reg_plan = '{16'h0000, 16'h0000, 16'h0000, 16'hF000, 16'h0000, 16'h0000};
            end else if (phase == 2) begin
                reg_plan = '{FEEDFORWARD_GAIN_RST, PROPORTIONAL_GAIN_RST, INTEGRAL_GAIN_RST,
                             16'(INTEGRAL_LIMIT_RST), 16'(RISE_STEP_RST),
                             16'(OUTPUT_LIMIT_RST)};
            end else begin
                plan_random();
            end
            load_config();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_item(make_item());
                if (phase == 3 && k == PHASE_ITEMS / 2) begin
                    wait_idle();
                end
            end
        end
        wait_idle();

        $display("Run covered %0d items and %0d checked results over %0d register settings,",
                 items_sent, results_seen, settings_used);
        $display("including gain and limit extremes and an output limit lowered mid-run.");
        if (fail_count == 0) begin
            $display("tb_dual_wheel_pi_velocity_loop_core: clean");
        end else begin
            $display("tb_dual_wheel_pi_velocity_loop_core: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/dwpi_pkg.sv
hw/rtl/dual_wheel_pi_velocity_loop_core.sv
verif/dwpi_loop_checker.sv
verif/tb_dual_wheel_pi_velocity_loop_core.sv
